// ===== rtl/tcrc32v_pkg.sv =====
package tcrc32v_pkg;

  localparam logic [31:0] CrcSeed  = 32'heada2d49;
  localparam logic [31:0] CrcTweak = 32'hd202ef8d;
  localparam logic [31:0] CrcPoly  = 32'hedb88320;

  typedef logic [31:0] crc_table_t [256];

  typedef struct packed {
    logic       valid;
    logic       last_byte;
    logic [7:0] data_byte;
  } stage_t;

  function automatic crc_table_t build_table();
    crc_table_t  tab;
    logic [31:0] v;
    for (int i = 0; i < 256; i++) begin
      v = 32'(i);
      for (int k = 0; k < 8; k++) begin
        if (v[0]) begin
          v = (v >> 1) ^ CrcPoly;
        end else begin
          v = v >> 1;
        end
      end
      tab[i] = v ^ CrcTweak;
    end
    return tab;
  endfunction

  localparam crc_table_t CrcTable = build_table();

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return CrcTable[idx] ^ {8'h00, crc[31:8]};
  endfunction

endpackage

// ===== rtl/tcrc32v_if.sv =====
interface tcrc32v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tcrc32v_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

// ===== rtl/tcrc32v_in_stage.sv =====
module tcrc32v_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcrc32v_in_if.sink          in_i,
  input  logic                take_i,
  output tcrc32v_pkg::stage_t stage_o
);
  import tcrc32v_pkg::*;

  logic       valid_q, valid_d;
  logic       last_q;
  logic [7:0] data_q;
  logic       accept;

  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_d    = accept || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign stage_o = '{valid: valid_q, last_byte: last_q, data_byte: data_q};

endmodule

// ===== rtl/tcrc32v_core.sv =====
module tcrc32v_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcrc32v_pkg::stage_t stage_i,
  output logic                take_o,
  tcrc32v_out_if.source       out_o
);
  import tcrc32v_pkg::*;

  logic [31:0] crc_q, crc_d;
  logic [31:0] sum_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] next_crc;
  logic        finish;

  assign next_crc = crc_step(crc_q, stage_i.data_byte);
  assign take_o   = stage_i.valid && (!stage_i.last_byte || !out_valid_q || out_o.ready);
  assign finish   = take_o && stage_i.last_byte;

  always_comb begin
    crc_d = crc_q;
    if (take_o) begin
      crc_d = finish ? CrcSeed : next_crc;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcSeed;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      sum_q <= next_crc;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.checksum = sum_q;

endmodule

// ===== rtl/table_crc32_variant_stream.sv =====
// Byte-stream CRC-32 (reflected, table driven, seeded) with one checksum per message.
// Input channel in_i: one transfer carries data_byte and last_byte; last_byte marks
// the final byte of a message. Output channel out_o: one transfer carries the
// finished 32-bit checksum of a message, with no final XOR.
// Throughput: one byte per cycle while out_o is not stalled, including across message boundaries.
// The checksum of a last byte is formed as that byte leaves the input register, and
// is held in the result register, from which out_o presents it.
// The path that sets the cycle time is one 256-entry table lookup and a 32-bit XOR
// from the running checksum register back into itself.
// Reset: the running checksum loads the seed, the input and result registers empty.
// After each last byte the running checksum returns to the seed.
// Stall: a waiting checksum holds on out_o until taken; bytes keep flowing until a
// further last byte reaches the input register while the result register is still
// full, then in_i.ready drops until the receiver takes the waiting checksum.
module table_crc32_variant_stream_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcrc32v_in_if.sink    in_i,
  tcrc32v_out_if.source out_o
);
  import tcrc32v_pkg::*;

  stage_t stage;
  logic   take;

  tcrc32v_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .stage_o(stage)
  );

  tcrc32v_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stage_i(stage),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/tcrc32v_checker.sv =====
module tcrc32v_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_checksum_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("checksum dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_checksum_i))
    else $error("checksum changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled checksum");

  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("checksum appeared without a last byte two cycles earlier");

endmodule

bind table_crc32_variant_stream_top tcrc32v_checker u_tcrc32v_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last_byte),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_checksum_i(out_o.checksum)
);

// ===== test/tcrc32v_checksum_checker.sv =====
`timescale 1ns / 1ps

module tcrc32v_checksum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_sum_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          compared_o
);
  import tcrc32v_pkg::*;

  logic [31:0] running_sum;
  logic [31:0] pending_sums[$];
  int          fails;
  int          compared;

  // Bit-serial fold of one byte, then the fixed tweak of the table entry.
  function automatic logic [31:0] fold_byte(logic [31:0] sum, logic [7:0] b);
    logic [31:0] acc;
    acc = sum ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CrcPoly) : (acc >> 1);
    end
    return acc ^ CrcTweak;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    compared_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] next_sum;
    logic [31:0] want;
    if (!rst_ni) begin
      running_sum = CrcSeed;
      pending_sums.delete();
      fails    = 0;
      compared = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        next_sum = fold_byte(running_sum, in_data_i);
        if (in_last_i) begin
          pending_sums.push_back(next_sum);
          running_sum = CrcSeed;
        end else begin
          running_sum = next_sum;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected checksum transfer: expected none, actual %08h",
                   $time, out_sum_i);
          fails++;
        end else begin
          want = pending_sums.pop_front();
          compared++;
          if (out_sum_i !== want) begin
            $display("%0t: checksum mismatch: expected %08h, actual %08h",
                     $time, want, out_sum_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_sums.size();
    compared_o   <= compared;
  end

endmodule

// ===== test/table_crc32_variant_stream_top_tb.sv =====
`timescale 1ns / 1ps

module table_crc32_variant_stream_top_tb;

  localparam int ByteTarget = 900;
  localparam int StallLimit = 5000;
  localparam int DrainWait  = 12;

  logic clk_i;
  logic rst_ni;

  tcrc32v_in_if  in_ch ();
  tcrc32v_out_if out_ch ();

  int fail_count;
  int pending;
  int compared;
  int bytes_sent;
  int msgs_sent;
  int burst_left;
  int rx_cycle;
  int rx_mode;

  table_crc32_variant_stream_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tcrc32v_checksum_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data_byte),
    .in_last_i    (in_ch.last_byte),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_sum_i    (out_ch.checksum),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // Receiver: drive out_ch.ready with a stall pattern that is re-picked at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_cycle = 0;
      rx_mode  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 150 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      case (rx_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ch.ready <= ((rx_cycle % 7) < 3);
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    do begin
      @(posedge clk_i);
    end while (!(in_ch.valid && in_ch.ready));
    burst_left--;
    bytes_sent++;
    if (is_last) begin
      msgs_sent++;
    end
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] msg[$];
    logic [7:0] walk[$];
    int         len;
    int         pick;
    bytes_sent = 0;
    msgs_sent  = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte messages at byte extremes and table ends, then multi-byte ones.
    send_message('{8'h00});
    send_message('{8'hff});
    send_message('{8'h49});
    send_message('{8'hb6});
    for (int i = 0; i < 8; i++) begin
      walk.push_back(8'h01 << i);
    end
    send_message(walk);
    send_message('{8'hff, 8'h00, 8'ha5, 8'h5a});
    send_message('{8'h12, 8'h34});

    while (bytes_sent < ByteTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(1, 12);
      end else if (pick < 95) begin
        len = $urandom_range(13, 40);
      end else begin
        len = 1;
      end
      msg.delete();
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
      send_message(msg);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages; %0d checksums compared, %0d mismatches.",
             bytes_sent, msgs_sent, compared, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
